// ===== rtl/stt_pkg.sv =====
// Shared types, codes and character helpers for the source text tokenizer.
package stt_pkg;

	localparam int LINE_BITS_DEF   = 16;
	localparam int COLUMN_BITS_DEF = 16;
	localparam int MAX_RES         = 3;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_NUM   = 3'd1,
		MODE_IDENT = 3'd2,
		MODE_STR   = 3'd3,
		MODE_CHR   = 3'd4,
		MODE_UNK   = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		KW_NONE = 3'd0,
		KW_F    = 3'd1,
		KW_FN   = 3'd2,
		KW_M    = 3'd3,
		KW_MU   = 3'd4,
		KW_MUT  = 3'd5
	} kw_t;

	localparam logic [4:0] TK_INT     = 5'd0;
	localparam logic [4:0] TK_FLOAT   = 5'd1;
	localparam logic [4:0] TK_IDENT   = 5'd2;
	localparam logic [4:0] TK_FN      = 5'd3;
	localparam logic [4:0] TK_MUT     = 5'd4;
	localparam logic [4:0] TK_STRING  = 5'd5;
	localparam logic [4:0] TK_CHAR    = 5'd6;
	localparam logic [4:0] TK_SYM0    = 5'd7;
	localparam logic [4:0] TK_UNKNOWN = 5'd20;
	localparam logic [4:0] TK_EOF     = 5'd21;

	localparam logic RK_VALUE = 1'b0;
	localparam logic RK_END   = 1'b1;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_NL    = 8'h0A;

	typedef struct packed {
		mode_t mode;
		logic  saw_dot;
		kw_t   kw;
	} scan_state_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  value_byte;
		logic [4:0]  token_kind;
		logic [15:0] start_line;
		logic [15:0] start_column;
	} res_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	// {hit, index} into the symbol list { } ( ) [ ] , : + - / * =
	function automatic logic [4:0] sym_lookup(input logic [7:0] c);
		logic [4:0] r;
		case (c)
			8'h7B:   r = {1'b1, 4'd0};
			8'h7D:   r = {1'b1, 4'd1};
			8'h28:   r = {1'b1, 4'd2};
			8'h29:   r = {1'b1, 4'd3};
			8'h5B:   r = {1'b1, 4'd4};
			8'h5D:   r = {1'b1, 4'd5};
			8'h2C:   r = {1'b1, 4'd6};
			8'h3A:   r = {1'b1, 4'd7};
			8'h2B:   r = {1'b1, 4'd8};
			8'h2D:   r = {1'b1, 4'd9};
			8'h2F:   r = {1'b1, 4'd10};
			8'h2A:   r = {1'b1, 4'd11};
			8'h3D:   r = {1'b1, 4'd12};
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic kw_t kw_next(input kw_t m, input logic [7:0] c);
		kw_t r;
		case (m)
			KW_F:    r = (c == 8'h6E) ? KW_FN  : KW_NONE;
			KW_M:    r = (c == 8'h75) ? KW_MU  : KW_NONE;
			KW_MU:   r = (c == 8'h74) ? KW_MUT : KW_NONE;
			default: r = KW_NONE;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/stt_in_if.sv =====
// Source byte channel: one byte or end-of-input mark per transaction.
interface stt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_mark;

	modport source (output valid, output ch, output end_mark, input ready);
	modport sink   (input valid, input ch, input end_mark, output ready);
endinterface

// ===== rtl/stt_out_if.sv =====
// Token result channel: one value byte or token end per transaction.
interface stt_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  value_byte;
	logic [4:0]  token_kind;
	logic [15:0] start_line;
	logic [15:0] start_column;
	logic        last;

	modport source (output valid, output kind, output value_byte, output token_kind,
		output start_line, output start_column, output last, input ready);
	modport sink   (input valid, input kind, input value_byte, input token_kind,
		input start_line, input start_column, input last, output ready);
endinterface

// ===== rtl/stt_lex.sv =====
// Per-byte scanner step: next scan state, next position and the result list.
module stt_lex #(
	parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF
) (
	input  logic [7:0]                 ch,
	input  logic                       end_mark,
	input  stt_pkg::scan_state_t       st,
	input  logic [LINE_BITS-1:0]       cur_line,
	input  logic [COLUMN_BITS-1:0]     cur_col,
	input  logic [LINE_BITS-1:0]       tok_line,
	input  logic [COLUMN_BITS-1:0]     tok_col,
	output stt_pkg::scan_state_t       st_nxt,
	output logic [LINE_BITS-1:0]       cur_line_nxt,
	output logic [COLUMN_BITS-1:0]     cur_col_nxt,
	output logic [LINE_BITS-1:0]       tok_line_nxt,
	output logic [COLUMN_BITS-1:0]     tok_col_nxt,
	output stt_pkg::res_t [2:0]        res,
	output logic [1:0]                 res_cnt
);
	import stt_pkg::*;

	logic       c_sp, c_dig, c_alp, c_dot;
	logic [4:0] sym;
	logic       f_close, f_val, f_sym, f_eof, do_start;
	logic [4:0] close_tk;
	res_t       cand [4];
	logic [3:0] flags;
	res_t       lst [4];
	logic [2:0] n;

	assign c_sp  = is_space(ch);
	assign c_dig = is_digit(ch);
	assign c_alp = is_alpha(ch);
	assign c_dot = (ch == CH_DOT);
	assign sym   = sym_lookup(ch);

	always_comb begin
		case (st.mode)
			MODE_NUM:   close_tk = st.saw_dot ? TK_FLOAT : TK_INT;
			MODE_IDENT: close_tk = (st.kw == KW_FN) ? TK_FN :
				(st.kw == KW_MUT) ? TK_MUT : TK_IDENT;
			MODE_STR:   close_tk = TK_STRING;
			MODE_CHR:   close_tk = TK_CHAR;
			default:    close_tk = TK_UNKNOWN;
		endcase
	end

	always_comb begin
		f_close     = 1'b0;
		f_val       = 1'b0;
		f_sym       = 1'b0;
		f_eof       = 1'b0;
		do_start    = 1'b0;
		st_nxt      = st;
		tok_line_nxt = tok_line;
		tok_col_nxt  = tok_col;
		if (end_mark) begin
			f_close = (st.mode != MODE_IDLE);
			f_eof   = 1'b1;
			st_nxt  = '{MODE_IDLE, 1'b0, KW_NONE};
		end else begin
			case (st.mode)
				MODE_NUM: begin
					if (c_dig || c_dot) begin
						f_val = 1'b1;
						if (c_dot) st_nxt.saw_dot = 1'b1;
					end else begin
						f_close  = 1'b1;
						do_start = 1'b1;
					end
				end
				MODE_IDENT: begin
					if (c_alp || c_dig || ch == CH_UNDER) begin
						f_val     = 1'b1;
						st_nxt.kw = kw_next(st.kw, ch);
					end else begin
						f_close  = 1'b1;
						do_start = 1'b1;
					end
				end
				MODE_STR, MODE_CHR: begin
					if (ch == ((st.mode == MODE_STR) ? CH_DQ : CH_SQ)) begin
						f_close = 1'b1;
						st_nxt  = '{MODE_IDLE, 1'b0, KW_NONE};
					end else begin
						f_val = 1'b1;
					end
				end
				MODE_UNK: begin
					if (c_sp) begin
						f_close = 1'b1;
						st_nxt  = '{MODE_IDLE, 1'b0, KW_NONE};
					end else begin
						f_val = 1'b1;
					end
				end
				default: do_start = 1'b1;
			endcase
			// byte that opens a token (or ends one and opens the next)
			if (do_start) begin
				st_nxt = '{MODE_IDLE, 1'b0, KW_NONE};
				if (!c_sp) begin
					tok_line_nxt = cur_line;
					tok_col_nxt  = cur_col;
					if (c_dig || c_dot) begin
						st_nxt.mode    = MODE_NUM;
						st_nxt.saw_dot = c_dot;
						f_val          = 1'b1;
					end else if (c_alp) begin
						st_nxt.mode = MODE_IDENT;
						st_nxt.kw   = (ch == 8'h66) ? KW_F : (ch == 8'h6D) ? KW_M : KW_NONE;
						f_val       = 1'b1;
					end else if (ch == CH_DQ) begin
						st_nxt.mode = MODE_STR;
					end else if (ch == CH_SQ) begin
						st_nxt.mode = MODE_CHR;
					end else if (sym[4]) begin
						f_val = 1'b1;
						f_sym = 1'b1;
					end else begin
						st_nxt.mode = MODE_UNK;
						f_val       = 1'b1;
					end
				end
			end
		end
	end

	// position advance, saturating
	always_comb begin
		cur_line_nxt = cur_line;
		cur_col_nxt  = cur_col;
		if (!end_mark) begin
			if (ch == CH_NL) begin
				if (cur_line != '1) cur_line_nxt = cur_line + LINE_BITS'(1);
				cur_col_nxt = COLUMN_BITS'(1);
			end else if (cur_col != '1) begin
				cur_col_nxt = cur_col + COLUMN_BITS'(1);
			end
		end
	end

	// results always come in the order close, value, symbol end, eof
	always_comb begin
		cand[0] = '{RK_END, 8'd0, close_tk, 16'(tok_line), 16'(tok_col)};
		cand[1] = '{RK_VALUE, ch, 5'd0, 16'd0, 16'd0};
		cand[2] = '{RK_END, 8'd0, TK_SYM0 + {1'b0, sym[3:0]}, 16'(cur_line), 16'(cur_col)};
		cand[3] = '{RK_END, 8'd0, TK_EOF, 16'(cur_line), 16'(cur_col)};
		flags   = {f_eof, f_sym, f_val, f_close};
	end

	always_comb begin
		n = 3'd0;
		for (int i = 0; i < 4; i++) lst[i] = '0;
		for (int i = 0; i < 4; i++) begin
			if (flags[i]) begin
				lst[n[1:0]] = cand[i];
				n = n + 3'd1;
			end
		end
	end

	assign res[0]  = lst[0];
	assign res[1]  = lst[1];
	assign res[2]  = lst[2];
	assign res_cnt = n[1:0];

endmodule

// ===== rtl/source_text_tokenizer_core.sv =====
// Top level of the streaming source text tokenizer.
// Source bytes arrive one per transaction on byte_in; an item with end_mark set closes
// any open token (an unterminated string or char included) and adds an end-of-file token.
// Each byte is scanned in the cycle it is accepted: the scan state and line/column
// counters update at once and the results it causes (zero to three: a token end for
// the token it closes, its own value byte, a one-byte symbol's end, or end-of-file)
// are written into a three-entry result buffer. The buffer drains on tok_out, one
// result per transaction, with last marking the final result of each input byte.
// Throughput: one input byte per cycle while each byte yields at most one result and
// tok_out is ready; a byte yielding n results occupies the output for n transactions,
// and the next byte is taken in the same cycle as the final one of those leaves.
// Bytes that yield no result (whitespace between tokens) pass at one per cycle.
// Positions start at line 1, column 1; a newline bumps the line and resets the
// column; both counters saturate and the ports carry their low 16 bits.
module source_text_tokenizer_core #(
	parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	stt_in_if.sink     byte_in,
	stt_out_if.source  tok_out
);
	import stt_pkg::*;

	// scanner state
	scan_state_t            st_q;
	logic [LINE_BITS-1:0]   cur_line_q;
	logic [COLUMN_BITS-1:0] cur_col_q;
	logic [LINE_BITS-1:0]   tok_line_q;
	logic [COLUMN_BITS-1:0] tok_col_q;

	scan_state_t            st_nxt;
	logic [LINE_BITS-1:0]   cur_line_nxt;
	logic [COLUMN_BITS-1:0] cur_col_nxt;
	logic [LINE_BITS-1:0]   tok_line_nxt;
	logic [COLUMN_BITS-1:0] tok_col_nxt;
	res_t [2:0]             res;
	logic [1:0]             res_cnt;

	// result buffer: cnt_q entries loaded, idx_q is the next one to send
	res_t       res_q [3];
	logic [1:0] cnt_q;
	logic [1:0] idx_q;
	res_t       res_cur;
	logic       out_last;
	logic       out_fire;
	logic       in_fire;

	stt_lex #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_lex (
		.ch           (byte_in.ch),
		.end_mark     (byte_in.end_mark),
		.st           (st_q),
		.cur_line     (cur_line_q),
		.cur_col      (cur_col_q),
		.tok_line     (tok_line_q),
		.tok_col      (tok_col_q),
		.st_nxt       (st_nxt),
		.cur_line_nxt (cur_line_nxt),
		.cur_col_nxt  (cur_col_nxt),
		.tok_line_nxt (tok_line_nxt),
		.tok_col_nxt  (tok_col_nxt),
		.res          (res),
		.res_cnt      (res_cnt)
	);

	assign out_last = (2'(idx_q + 2'd1) == cnt_q);
	assign out_fire = tok_out.valid && tok_out.ready;
	// take a new byte once the buffer is empty or its final result is leaving
	assign byte_in.ready = (idx_q == cnt_q) || (out_fire && out_last);
	assign in_fire = byte_in.valid && byte_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= '{MODE_IDLE, 1'b0, KW_NONE};
			cur_line_q <= LINE_BITS'(1);
			cur_col_q  <= COLUMN_BITS'(1);
			tok_line_q <= LINE_BITS'(1);
			tok_col_q  <= COLUMN_BITS'(1);
			cnt_q      <= 2'd0;
			idx_q      <= 2'd0;
		end else begin
			if (in_fire) begin
				st_q       <= st_nxt;
				cur_line_q <= cur_line_nxt;
				cur_col_q  <= cur_col_nxt;
				tok_line_q <= tok_line_nxt;
				tok_col_q  <= tok_col_nxt;
				cnt_q      <= res_cnt;
				idx_q      <= 2'd0;
			end else if (out_fire) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q[0] <= res[0];
			res_q[1] <= res[1];
			res_q[2] <= res[2];
		end
	end

	always_comb begin
		case (idx_q)
			2'd0:    res_cur = res_q[0];
			2'd1:    res_cur = res_q[1];
			default: res_cur = res_q[2];
		endcase
	end

	assign tok_out.valid        = (idx_q != cnt_q);
	assign tok_out.kind         = res_cur.kind;
	assign tok_out.value_byte   = res_cur.value_byte;
	assign tok_out.token_kind   = res_cur.token_kind;
	assign tok_out.start_line   = res_cur.start_line;
	assign tok_out.start_column = res_cur.start_column;
	assign tok_out.last         = out_last;

endmodule

// ===== rtl/stt_checker.sv =====
// Port-level checks for the tokenizer core, bound to the top level.
module stt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_kind,
	input logic [7:0]  out_value_byte,
	input logic [4:0]  out_token_kind,
	input logic [15:0] out_start_line,
	input logic [15:0] out_start_column,
	input logic        out_last
);
	import stt_pkg::*;

	// a stalled result holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
		$stable(out_value_byte) && $stable(out_token_kind) && $stable(out_last))
		else $error("stalled result changed");

	// while results are pending, a new byte is only taken as the buffer's final result leaves
	a_in_gate: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> out_ready && out_last)
		else $error("input accepted while results pending");

	// end-of-file is always the final result of its byte
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == RK_END && out_token_kind == TK_EOF |-> out_last)
		else $error("eof not last");

	// value results carry no token kind or position
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == RK_VALUE |->
		out_token_kind == 5'd0 && out_start_line == 16'd0 && out_start_column == 16'd0)
		else $error("value result with token fields");

endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (byte_in.valid),
	.in_ready         (byte_in.ready),
	.out_valid        (tok_out.valid),
	.out_ready        (tok_out.ready),
	.out_kind         (tok_out.kind),
	.out_value_byte   (tok_out.value_byte),
	.out_token_kind   (tok_out.token_kind),
	.out_start_line   (tok_out.start_line),
	.out_start_column (tok_out.start_column),
	.out_last         (tok_out.last)
);
